/* hw/rtl/rbs_pkg.sv */
// shared types and constants of the ray versus box slab test
`default_nettype none

package rbs_pkg;

   localparam int ID_WIDTH_DEF = 16;
   localparam int COORD_W      = 32;
   localparam int NUM_W        = COORD_W + 1;
   localparam int DIST_W       = 48;
   localparam int FRAC_W       = 16;
   localparam int ID_FIELD_W   = 16;
   localparam int NUM_AXES     = 3;
   localparam int AXIS_W       = 2;
   localparam int REQ_TDATA_W  = 208;
   localparam int RSP_TDATA_W  = 72;
   localparam int RSP_PAD_W    = RSP_TDATA_W - (1 + DIST_W + 1 + ID_FIELD_W);
   localparam int CSR_ADDR_W   = 3;
   localparam int DVD_W        = NUM_W + FRAC_W;
   localparam int DIV_STEPS    = DVD_W;
   localparam int DIV_CNT_W    = 6;

   localparam logic signed [DIST_W-1:0] T_LIMIT     = 48'sh0001_86A0_0000;
   localparam logic signed [DIST_W-1:0] T_LIMIT_NEG = -T_LIMIT;
   localparam logic signed [DIST_W-1:0] DIST_MAX    = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic signed [DIST_W-1:0] DIST_MIN    = {1'b1, {(DIST_W-1){1'b0}}};

   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_X = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_X    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_Y    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_DIR_Z    = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AXIS,
      ST_WAIT_A,
      ST_WAIT_B,
      ST_NARROW,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic                       start;
      logic signed [NUM_W-1:0]    num;
      logic signed [COORD_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [DIST_W-1:0]   quot;
   } div_rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/rbs_div.sv */
// shared radix-2 restoring divider, (num * 2^16) / den saturated to 48 bits
`default_nettype none

module rbs_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rbs_pkg::div_req_type req,
   output rbs_pkg::div_rsp_type      rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [rbs_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [rbs_pkg::DVD_W-1:0]     dvd_ff, dvd_in;
   logic [rbs_pkg::COORD_W-1:0]   rem_ff, rem_in;
   logic [rbs_pkg::COORD_W-1:0]   dsr_ff, dsr_in;
   logic                          neg_ff, neg_in;

   logic [rbs_pkg::NUM_W-1:0]     mag_n;
   logic [rbs_pkg::COORD_W-1:0]   mag_d;
   logic [rbs_pkg::COORD_W:0]     rem_sh;
   logic [rbs_pkg::COORD_W+1:0]   diff;
   logic                          qbit;

   always_comb begin
      mag_n  = req.num[rbs_pkg::NUM_W-1] ? rbs_pkg::NUM_W'(-req.num) : rbs_pkg::NUM_W'(req.num);
      mag_d  = req.den[rbs_pkg::COORD_W-1] ? rbs_pkg::COORD_W'(-req.den)
                                           : rbs_pkg::COORD_W'(req.den);
      rem_sh = {rem_ff, dvd_ff[rbs_pkg::DVD_W-1]};
      diff   = {1'b0, rem_sh} - {2'b00, dsr_ff};
      qbit   = ~diff[rbs_pkg::COORD_W+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;

      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = {mag_n, {rbs_pkg::FRAC_W{1'b0}}};
         rem_in  = '0;
         dsr_in  = mag_d;
         neg_in  = req.num[rbs_pkg::NUM_W-1] ^ req.den[rbs_pkg::COORD_W-1];
      end else if (busy_ff) begin
         rem_in = qbit ? diff[rbs_pkg::COORD_W-1:0] : rem_sh[rbs_pkg::COORD_W-1:0];
         dvd_in = {dvd_ff[rbs_pkg::DVD_W-2:0], qbit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == rbs_pkg::DIV_CNT_W'(rbs_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // saturate the magnitude quotient to the signed distance range
   always_comb begin
      rsp.done = done_ff;
      if (!neg_ff) begin
         if (dvd_ff[rbs_pkg::DVD_W-1:rbs_pkg::DIST_W-1] != '0) begin
            rsp.quot = rbs_pkg::DIST_MAX;
         end else begin
            rsp.quot = dvd_ff[rbs_pkg::DIST_W-1:0];
         end
      end else begin
         if (dvd_ff[rbs_pkg::DVD_W-1:rbs_pkg::DIST_W-1] != '0) begin
            rsp.quot = rbs_pkg::DIST_MIN;
         end else begin
            rsp.quot = -$signed(dvd_ff[rbs_pkg::DIST_W-1:0]);
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ray_box_slab_first_hit.sv */
// ray versus axis-aligned box slab test with first hit of a pick pass
//
// The ray origin and direction are set through the csr_ write port; the user must write them
// only while the block is idle, as the block itself does not enforce it. Each req_ transfer
// carries one box (two corners, object ID, tlast ending the pass) and yields one rsp_ transfer
// with the hit flag, entry distance and the first hit so far; rsp_tlast repeats the pass end,
// after which the first hit is cleared. Each axis with nonzero direction that is still open
// takes both slab quotients in turn from the single 49-step radix-2 divider, and each
// zero-direction axis is passed over. req_tready is high only between boxes; a finished
// result waits in the output register while the next box is taken, but that box's result
// is not loaded until the waiting one is taken.
`default_nettype none

module ray_box_slab_first_hit #(
   parameter int ID_WIDTH = rbs_pkg::ID_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y, corner_b_z, object_id
   input  wire logic [rbs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire logic                               req_tlast,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // box_hit, entry_distance, any_found, first_hit_id, zero fill
   output      logic [rbs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output      logic                               rsp_tlast,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_we,
   input  wire logic [rbs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [rbs_pkg::COORD_W-1:0]        csr_wdata
);

   localparam int KEEP_W = (ID_WIDTH < rbs_pkg::ID_FIELD_W) ? ID_WIDTH : rbs_pkg::ID_FIELD_W;
   localparam int CW     = rbs_pkg::COORD_W;

   rbs_pkg::state_type state_ff, state_in;

   logic signed [CW-1:0] origin_ff [rbs_pkg::NUM_AXES];
   logic signed [CW-1:0] origin_in [rbs_pkg::NUM_AXES];
   logic signed [CW-1:0] dir_ff    [rbs_pkg::NUM_AXES];
   logic signed [CW-1:0] dir_in    [rbs_pkg::NUM_AXES];
   logic signed [CW-1:0] ca_ff     [rbs_pkg::NUM_AXES];
   logic signed [CW-1:0] ca_in     [rbs_pkg::NUM_AXES];
   logic signed [CW-1:0] cb_ff     [rbs_pkg::NUM_AXES];
   logic signed [CW-1:0] cb_in     [rbs_pkg::NUM_AXES];

   logic [KEEP_W-1:0]                    id_ff, id_in;
   logic                                 last_ff, last_in;
   logic [rbs_pkg::AXIS_W-1:0]           axis_ff, axis_in;
   logic signed [rbs_pkg::DIST_W-1:0]    tmin_ff, tmin_in;
   logic signed [rbs_pkg::DIST_W-1:0]    tmax_ff, tmax_in;
   logic signed [rbs_pkg::DIST_W-1:0]    ta_ff, ta_in;
   logic signed [rbs_pkg::DIST_W-1:0]    tb_ff, tb_in;
   logic                                 found_ff, found_in;
   logic [KEEP_W-1:0]                    first_ff, first_in;
   logic [rbs_pkg::RSP_TDATA_W-1:0]      rsp_tdata_ff, rsp_tdata_in;
   logic                                 rsp_tlast_ff, rsp_tlast_in;
   logic                                 rsp_valid_ff, rsp_valid_in;

   rbs_pkg::div_req_type div_req;
   rbs_pkg::div_rsp_type div_rsp;

   logic                              accept;
   logic                              empty;
   logic                              axis_done;
   logic                              dir_zero;
   logic                              result_load;
   logic                              hit;
   logic                              found_now;
   logic [KEEP_W-1:0]                 first_now;
   logic signed [rbs_pkg::DIST_W-1:0] entry;
   logic signed [rbs_pkg::DIST_W-1:0] lo;
   logic signed [rbs_pkg::DIST_W-1:0] hi;
   logic signed [rbs_pkg::NUM_W-1:0]  diff_a;
   logic signed [rbs_pkg::NUM_W-1:0]  diff_b;

   rbs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept    = req_tvalid && req_tready;
   assign empty     = tmax_ff < tmin_ff;
   assign axis_done = axis_ff == rbs_pkg::AXIS_W'(rbs_pkg::NUM_AXES);
   assign dir_zero  = dir_ff[axis_ff] == '0;
   assign diff_a    = $signed({ca_ff[axis_ff][CW-1], ca_ff[axis_ff]})
                    - $signed({origin_ff[axis_ff][CW-1], origin_ff[axis_ff]});
   assign diff_b    = $signed({cb_ff[axis_ff][CW-1], cb_ff[axis_ff]})
                    - $signed({origin_ff[axis_ff][CW-1], origin_ff[axis_ff]});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rbs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = rbs_pkg::ST_AXIS;
            end
         end
         rbs_pkg::ST_AXIS: begin
            if (empty || axis_done) begin
               state_in = rbs_pkg::ST_RESULT;
            end else if (!dir_zero) begin
               state_in = rbs_pkg::ST_WAIT_A;
            end
         end
         rbs_pkg::ST_WAIT_A: begin
            if (div_rsp.done) begin
               state_in = rbs_pkg::ST_WAIT_B;
            end
         end
         rbs_pkg::ST_WAIT_B: begin
            if (div_rsp.done) begin
               state_in = rbs_pkg::ST_NARROW;
            end
         end
         rbs_pkg::ST_NARROW: begin
            state_in = rbs_pkg::ST_AXIS;
         end
         rbs_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = rbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbs_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready    = 1'b0;
      result_load   = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = diff_a;
      div_req.den   = dir_ff[axis_ff];
      case (state_ff)
         rbs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         rbs_pkg::ST_AXIS: begin
            div_req.start = !empty && !axis_done && !dir_zero;
         end
         rbs_pkg::ST_WAIT_A: begin
            div_req.start = div_rsp.done;
            div_req.num   = diff_b;
         end
         rbs_pkg::ST_RESULT: begin
            result_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      origin_in    = origin_ff;
      dir_in       = dir_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      id_in        = id_ff;
      last_in      = last_ff;
      axis_in      = axis_ff;
      tmin_in      = tmin_ff;
      tmax_in      = tmax_ff;
      ta_in        = ta_ff;
      tb_in        = tb_ff;
      found_in     = found_ff;
      first_in     = first_ff;
      rsp_tdata_in = rsp_tdata_ff;
      rsp_tlast_in = rsp_tlast_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      lo        = (ta_ff < tb_ff) ? ta_ff : tb_ff;
      hi        = (ta_ff < tb_ff) ? tb_ff : ta_ff;
      hit       = !empty && !tmin_ff[rbs_pkg::DIST_W-1];
      found_now = found_ff || hit;
      first_now = (hit && !found_ff) ? id_ff : first_ff;
      entry     = empty ? '0 : tmin_ff;

      if (csr_we) begin
         case (csr_addr)
            rbs_pkg::REG_ORIGIN_X: origin_in[0] = csr_wdata;
            rbs_pkg::REG_ORIGIN_Y: origin_in[1] = csr_wdata;
            rbs_pkg::REG_ORIGIN_Z: origin_in[2] = csr_wdata;
            rbs_pkg::REG_DIR_X:    dir_in[0]    = csr_wdata;
            rbs_pkg::REG_DIR_Y:    dir_in[1]    = csr_wdata;
            rbs_pkg::REG_DIR_Z:    dir_in[2]    = csr_wdata;
            default: begin
               origin_in = origin_ff;
            end
         endcase
      end

      if (accept) begin
         for (int i = 0; i < rbs_pkg::NUM_AXES; i++) begin
            ca_in[i] = req_tdata[i*CW +: CW];
            cb_in[i] = req_tdata[(i + rbs_pkg::NUM_AXES)*CW +: CW];
         end
         id_in   = req_tdata[2*rbs_pkg::NUM_AXES*CW +: KEEP_W];
         last_in = req_tlast;
         axis_in = '0;
         tmin_in = rbs_pkg::T_LIMIT_NEG;
         tmax_in = rbs_pkg::T_LIMIT;
      end

      case (state_ff)
         rbs_pkg::ST_AXIS: begin
            if (!empty && !axis_done && dir_zero) begin
               axis_in = axis_ff + 1'b1;
            end
         end
         rbs_pkg::ST_WAIT_A: begin
            if (div_rsp.done) begin
               ta_in = div_rsp.quot;
            end
         end
         rbs_pkg::ST_WAIT_B: begin
            if (div_rsp.done) begin
               tb_in = div_rsp.quot;
            end
         end
         rbs_pkg::ST_NARROW: begin
            if (lo > tmin_ff) begin
               tmin_in = lo;
            end
            if (hi < tmax_ff) begin
               tmax_in = hi;
            end
            axis_in = axis_ff + 1'b1;
         end
         rbs_pkg::ST_RESULT: begin
            if (result_load) begin
               rsp_tdata_in = {{rbs_pkg::RSP_PAD_W{1'b0}}, rbs_pkg::ID_FIELD_W'(first_now),
                               found_now, entry, hit};
               rsp_tlast_in = last_ff;
               rsp_valid_in = 1'b1;
               found_in     = last_ff ? 1'b0 : found_now;
               first_in     = last_ff ? '0 : first_now;
            end
         end
         default: begin
            ta_in = ta_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rbs_pkg::ST_IDLE;
         axis_ff      <= '0;
         found_ff     <= 1'b0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rbs_pkg::NUM_AXES; i++) begin
            origin_ff[i] <= '0;
            dir_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         found_ff     <= found_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         origin_ff    <= origin_in;
         dir_ff       <= dir_in;
      end
      ca_ff        <= ca_in;
      cb_ff        <= cb_in;
      id_ff        <= id_in;
      last_ff      <= last_in;
      tmin_ff      <= tmin_in;
      tmax_ff      <= tmax_in;
      ta_ff        <= ta_in;
      tb_ff        <= tb_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire
